// File: rtl/stop_and_wait_arq_sender_unit_defines.svh
// ----------------------------------------------------------------------------
// stop-and-wait arq sender assertion macros
// shared concurrent assertion wrappers, clocked on aclk, off during reset
// ----------------------------------------------------------------------------
`ifndef STOP_AND_WAIT_ARQ_SENDER_UNIT_DEFINES_SVH
`define STOP_AND_WAIT_ARQ_SENDER_UNIT_DEFINES_SVH

// property must hold at every clock edge outside reset
`define SAWARQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// condition must never be seen outside reset
`define SAWARQ_NEVER(lbl, cond, msg) \
    `SAWARQ_ASSERT(lbl, !(cond), msg)

`endif

// File: rtl/sawarq_pkg.sv
// ----------------------------------------------------------------------------
// sawarq_pkg
// types, codes and constants of the stop-and-wait arq sender
// ----------------------------------------------------------------------------
package sawarq_pkg;

    localparam int SEQ_MODULUS_DEF = 4;
    localparam int SEQ_W           = 8;
    localparam int NODE_W          = 8;
    localparam int RETRY_W         = 4;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 8;
    localparam int FIFO_DEPTH      = 4;
    localparam logic [RETRY_W-1:0] MAX_RETRIES_RST = 4'd4;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_TX   = 2'd1,
        ST_ACK  = 2'd2
    } state_t;

    typedef enum logic [2:0] {
        OP_SEND_REQ  = 3'd0,
        OP_DATA_SENT = 3'd1,
        OP_ACK_SENT  = 3'd2,
        OP_ACK_RX    = 3'd3,
        OP_TIMEOUT   = 3'd4,
        OP_DATA_RX   = 3'd5,
        OP_RSVD6     = 3'd6,
        OP_RSVD7     = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        ACT_NONE     = 3'd0,
        ACT_SEND     = 3'd1,
        ACT_RESEND   = 3'd2,
        ACT_SEND_ACK = 3'd3,
        ACT_ACK_OK   = 3'd4,
        ACT_MISMATCH = 3'd5,
        ACT_GIVE_UP  = 3'd6,
        ACT_IGNORED  = 3'd7
    } action_t;

    typedef enum logic [1:0] {
        TMR_NONE  = 2'd0,
        TMR_START = 2'd1,
        TMR_STOP  = 2'd2
    } timer_cmd_t;

    localparam logic [CFG_IDX_W-1:0] CFG_DEST_NODE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES = 1'd1;

    typedef struct packed {
        action_t            action;
        logic [SEQ_W-1:0]   seq;
        logic [NODE_W-1:0]  dest;
        timer_cmd_t         tcmd;
        logic [1:0]         state;
        logic               last;
    } res_t;

endpackage

// File: rtl/stop_and_wait_arq_sender_unit.sv
// an accepted event's results are queued and offered in order from the queue head
// throughput: one event per cycle while each event gives one result and m_axis_tready
//   is high; an event that gives two results (deferred timeout) queues both of them
// the 4-entry result queue sets the rate: s_axis_tready needs room for two results
// reset: synchronous active-low aresetn; state idle, counters zero, queue empty,
//   dest_node 0, max_retries 4
// ----------------------------------------------------------------------------
// stop_and_wait_arq_sender_unit
// stop-and-wait arq control: one protocol event in, one or two result items out
// ----------------------------------------------------------------------------
`include "stop_and_wait_arq_sender_unit_defines.svh"

module stop_and_wait_arq_sender_unit #(
    parameter int SEQ_MODULUS = sawarq_pkg::SEQ_MODULUS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sawarq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sawarq_pkg::CFG_DATA_W-1:0] cfg_data,

    // event input
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [15:0]                       s_axis_tdata,  // rx_seq[7:0], rx_source[15:8]
    input  logic [2:0]                        s_axis_tuser,  // op[2:0]

    // result output
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [23:0]                       m_axis_tdata,  // seq_out[7:0], dest_out[15:8],
                                                             // timer_cmd[17:16],
                                                             // state_out[19:18], zero[23:20]
    output logic [2:0]                        m_axis_tuser,  // action[2:0]
    output logic                              m_axis_tlast
);

    localparam int PTR_W = $clog2(sawarq_pkg::FIFO_DEPTH);
    localparam int CNT_W = $clog2(sawarq_pkg::FIFO_DEPTH + 1);
    localparam logic [sawarq_pkg::SEQ_W-1:0] SEQ_TOP = sawarq_pkg::SEQ_W'(SEQ_MODULUS - 1);

    // configuration registers
    logic [sawarq_pkg::NODE_W-1:0]  dest_node_reg;
    logic [sawarq_pkg::RETRY_W-1:0] max_retries_reg;

    // protocol state
    sawarq_pkg::state_t             state_reg, state_next;
    logic [sawarq_pkg::SEQ_W-1:0]   next_seq_reg, next_seq_next;
    logic [sawarq_pkg::SEQ_W-1:0]   sent_seq_reg, sent_seq_next;
    logic [sawarq_pkg::RETRY_W-1:0] retry_reg, retry_next;
    logic                           timer_run_reg, timer_run_next;
    logic                           tmo_pend_reg, tmo_pend_next;

    // result queue
    sawarq_pkg::res_t               fifo_reg [sawarq_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]               wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]               rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]               count_reg, count_next;

    // event decode
    sawarq_pkg::op_t                op;
    logic [sawarq_pkg::SEQ_W-1:0]   rx_seq;
    logic [sawarq_pkg::NODE_W-1:0]  rx_source;
    logic                           s_fire;
    logic                           m_fire;
    logic                           timer_eff;   // timer flag after a timeout expires it
    logic                           give_up;
    logic                           tx_to_ack;   // tx leaves for the ack state
    logic                           two_res;     // deferred timeout adds a second item
    sawarq_pkg::res_t               res0, res1, tmo_res;
    logic [1:0]                     push_n;

    assign op        = sawarq_pkg::op_t'(s_axis_tuser);
    assign rx_seq    = s_axis_tdata[7:0];
    assign rx_source = s_axis_tdata[15:8];
    assign s_fire    = s_axis_tvalid & s_axis_tready;
    assign m_fire    = m_axis_tvalid & m_axis_tready;

    assign timer_eff = timer_run_reg & (op != sawarq_pkg::OP_TIMEOUT);
    assign give_up   = retry_reg >= max_retries_reg;
    assign tx_to_ack = (op == sawarq_pkg::OP_DATA_SENT) ||
                       ((op == sawarq_pkg::OP_ACK_SENT) && (timer_eff || tmo_pend_reg));
    assign two_res   = (state_reg == sawarq_pkg::ST_TX) && tx_to_ack && tmo_pend_reg;

    // config writes, always accepted
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dest_node_reg   <= '0;
            max_retries_reg <= sawarq_pkg::MAX_RETRIES_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                sawarq_pkg::CFG_DEST_NODE:   dest_node_reg   <= cfg_data;
                sawarq_pkg::CFG_MAX_RETRIES: max_retries_reg <= cfg_data[sawarq_pkg::RETRY_W-1:0];
                default: ;
            endcase
        end
    end

    // timeout result: resend or give up, for a timeout in the ack state or a deferred one
    always_comb begin
        tmo_res = '0;
        tmo_res.seq  = sent_seq_reg;
        tmo_res.tcmd = sawarq_pkg::TMR_NONE;
        tmo_res.last = 1'b1;
        if (give_up) begin
            tmo_res.action = sawarq_pkg::ACT_GIVE_UP;
            tmo_res.state  = sawarq_pkg::ST_IDLE;
        end else begin
            tmo_res.action = sawarq_pkg::ACT_RESEND;
            tmo_res.dest   = dest_node_reg;
            tmo_res.state  = sawarq_pkg::ST_TX;
        end
    end

    // next state of the protocol machine
    always_comb begin
        state_next     = state_reg;
        next_seq_next  = next_seq_reg;
        sent_seq_next  = sent_seq_reg;
        retry_next     = retry_reg;
        timer_run_next = timer_eff;
        tmo_pend_next  = tmo_pend_reg;
        unique case (state_reg)
            sawarq_pkg::ST_IDLE: begin
                if (op == sawarq_pkg::OP_SEND_REQ) begin
                    sent_seq_next = next_seq_reg;
                    next_seq_next = (next_seq_reg == SEQ_TOP) ? '0
                                  : sawarq_pkg::SEQ_W'(next_seq_reg + 1'b1);
                    retry_next    = '0;
                    state_next    = sawarq_pkg::ST_TX;
                end
            end
            sawarq_pkg::ST_TX: begin
                case (op)
                    sawarq_pkg::OP_ACK_SENT:
                        state_next = (timer_eff || tmo_pend_reg) ? sawarq_pkg::ST_ACK
                                                                 : sawarq_pkg::ST_IDLE;
                    sawarq_pkg::OP_DATA_SENT: begin
                        state_next     = sawarq_pkg::ST_ACK;
                        timer_run_next = 1'b1;
                    end
                    sawarq_pkg::OP_TIMEOUT:
                        tmo_pend_next = 1'b1;
                    default: ;
                endcase
                // deferred timeout is served on the way into the ack state
                if (two_res) begin
                    tmo_pend_next = 1'b0;
                    if (give_up) begin
                        state_next = sawarq_pkg::ST_IDLE;
                    end else begin
                        retry_next = sawarq_pkg::RETRY_W'(retry_reg + 1'b1);
                        state_next = sawarq_pkg::ST_TX;
                    end
                end
            end
            sawarq_pkg::ST_ACK: begin
                case (op)
                    sawarq_pkg::OP_ACK_RX: begin
                        if (rx_seq == sent_seq_reg) begin
                            timer_run_next = 1'b0;
                            state_next     = sawarq_pkg::ST_IDLE;
                        end
                    end
                    sawarq_pkg::OP_TIMEOUT: begin
                        if (give_up) begin
                            state_next = sawarq_pkg::ST_IDLE;
                        end else begin
                            retry_next = sawarq_pkg::RETRY_W'(retry_reg + 1'b1);
                            state_next = sawarq_pkg::ST_TX;
                        end
                    end
                    sawarq_pkg::OP_DATA_RX:
                        state_next = sawarq_pkg::ST_TX;
                    default: ;
                endcase
            end
            default: state_next = sawarq_pkg::ST_IDLE;
        endcase
    end

    // result items of the event
    always_comb begin
        res0        = '0;
        res0.action = sawarq_pkg::ACT_IGNORED;
        res0.tcmd   = sawarq_pkg::TMR_NONE;
        res0.state  = state_reg;
        res0.last   = 1'b1;
        res1        = tmo_res;
        unique case (state_reg)
            sawarq_pkg::ST_IDLE: begin
                if (op == sawarq_pkg::OP_SEND_REQ) begin
                    res0.action = sawarq_pkg::ACT_SEND;
                    res0.seq    = next_seq_reg;
                    res0.dest   = dest_node_reg;
                    res0.state  = sawarq_pkg::ST_TX;
                end
            end
            sawarq_pkg::ST_TX: begin
                case (op)
                    sawarq_pkg::OP_ACK_SENT: begin
                        res0.action = sawarq_pkg::ACT_NONE;
                        res0.state  = (timer_eff || tmo_pend_reg) ? sawarq_pkg::ST_ACK
                                                                  : sawarq_pkg::ST_IDLE;
                    end
                    sawarq_pkg::OP_DATA_SENT: begin
                        res0.action = sawarq_pkg::ACT_NONE;
                        res0.tcmd   = sawarq_pkg::TMR_START;
                        res0.state  = sawarq_pkg::ST_ACK;
                    end
                    sawarq_pkg::OP_TIMEOUT:
                        res0.action = sawarq_pkg::ACT_NONE;
                    default: ;
                endcase
                if (two_res) begin
                    res0.last = 1'b0;
                end
            end
            sawarq_pkg::ST_ACK: begin
                case (op)
                    sawarq_pkg::OP_ACK_RX: begin
                        res0.seq = rx_seq;
                        if (rx_seq == sent_seq_reg) begin
                            res0.action = sawarq_pkg::ACT_ACK_OK;
                            res0.tcmd   = sawarq_pkg::TMR_STOP;
                            res0.state  = sawarq_pkg::ST_IDLE;
                        end else begin
                            res0.action = sawarq_pkg::ACT_MISMATCH;
                        end
                    end
                    sawarq_pkg::OP_TIMEOUT:
                        res0 = tmo_res;
                    sawarq_pkg::OP_DATA_RX: begin
                        res0.action = sawarq_pkg::ACT_SEND_ACK;
                        res0.seq    = rx_seq;
                        res0.dest   = rx_source;
                        res0.state  = sawarq_pkg::ST_TX;
                    end
                    default: ;
                endcase
            end
            default: res0.state = sawarq_pkg::ST_IDLE;
        endcase
    end

    // queue bookkeeping
    assign push_n = !s_fire ? 2'd0 : (two_res ? 2'd2 : 2'd1);

    always_comb begin
        wr_ptr_next = PTR_W'(wr_ptr_reg + push_n);
        rd_ptr_next = m_fire ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = CNT_W'(count_reg + push_n - CNT_W'(m_fire));
    end

    // accept only with room for the largest burst of two items
    assign s_axis_tready = count_reg <= CNT_W'(sawarq_pkg::FIFO_DEPTH - 2);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= sawarq_pkg::ST_IDLE;
            next_seq_reg  <= '0;
            sent_seq_reg  <= '0;
            retry_reg     <= '0;
            timer_run_reg <= 1'b0;
            tmo_pend_reg  <= 1'b0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
        end else begin
            if (s_fire) begin
                state_reg     <= state_next;
                next_seq_reg  <= next_seq_next;
                sent_seq_reg  <= sent_seq_next;
                retry_reg     <= retry_next;
                timer_run_reg <= timer_run_next;
                tmo_pend_reg  <= tmo_pend_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage, payload only
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            fifo_reg[wr_ptr_reg] <= res0;
            if (two_res) begin
                fifo_reg[PTR_W'(wr_ptr_reg + 1'b1)] <= res1;
            end
        end
    end

    // head of queue drives the result port
    assign m_axis_tvalid = count_reg != '0;
    assign m_axis_tuser  = fifo_reg[rd_ptr_reg].action;
    assign m_axis_tlast  = fifo_reg[rd_ptr_reg].last;
    assign m_axis_tdata  = {4'b0000, fifo_reg[rd_ptr_reg].state, fifo_reg[rd_ptr_reg].tcmd,
                            fifo_reg[rd_ptr_reg].dest, fifo_reg[rd_ptr_reg].seq};

    // queue never overfills
    `SAWARQ_NEVER(a_fifo_bound, count_reg > CNT_W'(sawarq_pkg::FIFO_DEPTH),
                  "result queue overflow")
    // a non-final item always has its partner queued behind it
    `SAWARQ_ASSERT(a_pair_queued, (m_axis_tvalid && !m_axis_tlast) |-> (count_reg >= 2),
                   "first of two items without its second")
    // a pending timeout exists only while transmitting
    `SAWARQ_ASSERT(a_pend_tx, tmo_pend_reg |-> (state_reg == sawarq_pkg::ST_TX),
                   "pending timeout outside tx")
    // a send request in idle always moves to tx
    `SAWARQ_ASSERT(a_send_tx,
                   (s_fire && (state_reg == sawarq_pkg::ST_IDLE) &&
                    (op == sawarq_pkg::OP_SEND_REQ)) |=> (state_reg == sawarq_pkg::ST_TX),
                   "send request did not enter tx")

endmodule

// File: tb/tb_stop_and_wait_arq_sender_unit.sv
// ----------------------------------------------------------------------------
// tb_stop_and_wait_arq_sender_unit
// self-checking bench for the stop-and-wait arq control block: protocol events
// go in over the input stream, and a cycle-free model of the sender predicts
// every result item, which is checked field by field as it leaves the block
// ----------------------------------------------------------------------------
module tb_stop_and_wait_arq_sender_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SEQ_MOD     = sawarq_pkg::SEQ_MODULUS_DEF;
    localparam int N_PHASES    = 6;
    localparam int PHASE_ITEMS = 188;
    localparam int LONG_HOLD   = 150;  // receiver stall used to fill the result queue
    localparam int DRAIN_WAIT  = 20;

    // ------------------------------------------------------------------------
    // arq sender model: tracks protocol state and queues the result items
    // each accepted event is expected to produce
    // ------------------------------------------------------------------------
    class arq_tracker;
        sawarq_pkg::state_t proto_state;
        logic [7:0]         next_seq;
        logic [7:0]         sent_seq;
        logic [3:0]         retry_count;
        bit                 timer_running;
        bit                 timeout_pending;
        logic [7:0]         dest_node;
        logic [3:0]         max_retries;
        sawarq_pkg::res_t   pending_results[$];
        int                 errors;

        function new();
            proto_state     = sawarq_pkg::ST_IDLE;
            next_seq        = '0;
            sent_seq        = '0;
            retry_count     = '0;
            timer_running   = 1'b0;
            timeout_pending = 1'b0;
            dest_node       = '0;
            max_retries     = sawarq_pkg::MAX_RETRIES_RST;
            errors          = 0;
        endfunction

        function void write_reg(logic [sawarq_pkg::CFG_IDX_W-1:0] idx,
                                logic [sawarq_pkg::CFG_DATA_W-1:0] val);
            if (idx == sawarq_pkg::CFG_DEST_NODE) begin
                dest_node = val;
            end else if (idx == sawarq_pkg::CFG_MAX_RETRIES) begin
                max_retries = val[3:0];
            end
        endfunction

        // state_out carries the state as it stands when the item is formed
        function void add_result(sawarq_pkg::action_t act, logic [7:0] seq, logic [7:0] dest,
                                 sawarq_pkg::timer_cmd_t tcmd);
            sawarq_pkg::res_t r;
            r.action = act;
            r.seq    = seq;
            r.dest   = dest;
            r.tcmd   = tcmd;
            r.state  = proto_state;
            r.last   = 1'b0;
            pending_results.push_back(r);
        endfunction

        // expired timer, in ack wait or deferred from tx: resend or give up
        function void resolve_timeout();
            if (retry_count >= max_retries) begin
                proto_state = sawarq_pkg::ST_IDLE;
                add_result(sawarq_pkg::ACT_GIVE_UP, sent_seq, 8'h00, sawarq_pkg::TMR_NONE);
            end else begin
                retry_count = retry_count + 4'd1;
                proto_state = sawarq_pkg::ST_TX;
                add_result(sawarq_pkg::ACT_RESEND, sent_seq, dest_node, sawarq_pkg::TMR_NONE);
            end
        endfunction

        function void apply_event(sawarq_pkg::op_t op, logic [7:0] rx_seq,
                                  logic [7:0] rx_source);
            bit to_ack;
            to_ack = 1'b0;
            if (op == sawarq_pkg::OP_TIMEOUT) begin
                timer_running = 1'b0;
            end
            case (proto_state)
                sawarq_pkg::ST_IDLE: begin
                    if (op == sawarq_pkg::OP_SEND_REQ) begin
                        sent_seq    = next_seq;
                        next_seq    = 8'((int'(next_seq) + 1) % SEQ_MOD);
                        retry_count = '0;
                        proto_state = sawarq_pkg::ST_TX;
                        add_result(sawarq_pkg::ACT_SEND, sent_seq, dest_node,
                                   sawarq_pkg::TMR_NONE);
                    end else begin
                        add_result(sawarq_pkg::ACT_IGNORED, 8'h00, 8'h00,
                                   sawarq_pkg::TMR_NONE);
                    end
                end
                sawarq_pkg::ST_TX: begin
                    if (op == sawarq_pkg::OP_ACK_SENT) begin
                        if (timer_running || timeout_pending) begin
                            proto_state = sawarq_pkg::ST_ACK;
                            to_ack      = 1'b1;
                        end else begin
                            proto_state = sawarq_pkg::ST_IDLE;
                        end
                        add_result(sawarq_pkg::ACT_NONE, 8'h00, 8'h00, sawarq_pkg::TMR_NONE);
                    end else if (op == sawarq_pkg::OP_DATA_SENT) begin
                        proto_state   = sawarq_pkg::ST_ACK;
                        timer_running = 1'b1;
                        to_ack        = 1'b1;
                        add_result(sawarq_pkg::ACT_NONE, 8'h00, 8'h00, sawarq_pkg::TMR_START);
                    end else if (op == sawarq_pkg::OP_TIMEOUT) begin
                        timeout_pending = 1'b1;
                        add_result(sawarq_pkg::ACT_NONE, 8'h00, 8'h00, sawarq_pkg::TMR_NONE);
                    end else begin
                        add_result(sawarq_pkg::ACT_IGNORED, 8'h00, 8'h00,
                                   sawarq_pkg::TMR_NONE);
                    end
                    // a timeout seen while transmitting is handled on entry to ack wait
                    if (to_ack && timeout_pending) begin
                        timeout_pending = 1'b0;
                        resolve_timeout();
                    end
                end
                sawarq_pkg::ST_ACK: begin
                    if (op == sawarq_pkg::OP_ACK_RX) begin
                        if (rx_seq == sent_seq) begin
                            timer_running = 1'b0;
                            proto_state   = sawarq_pkg::ST_IDLE;
                            add_result(sawarq_pkg::ACT_ACK_OK, rx_seq, 8'h00,
                                       sawarq_pkg::TMR_STOP);
                        end else begin
                            add_result(sawarq_pkg::ACT_MISMATCH, rx_seq, 8'h00,
                                       sawarq_pkg::TMR_NONE);
                        end
                    end else if (op == sawarq_pkg::OP_TIMEOUT) begin
                        resolve_timeout();
                    end else if (op == sawarq_pkg::OP_DATA_RX) begin
                        proto_state = sawarq_pkg::ST_TX;
                        add_result(sawarq_pkg::ACT_SEND_ACK, rx_seq, rx_source,
                                   sawarq_pkg::TMR_NONE);
                    end else begin
                        add_result(sawarq_pkg::ACT_IGNORED, 8'h00, 8'h00,
                                   sawarq_pkg::TMR_NONE);
                    end
                end
                default: begin
                    proto_state = sawarq_pkg::ST_IDLE;
                    add_result(sawarq_pkg::ACT_IGNORED, 8'h00, 8'h00, sawarq_pkg::TMR_NONE);
                end
            endcase
            pending_results[pending_results.size() - 1].last = 1'b1;
        endfunction

        function void check_result(logic [23:0] tdata, logic [2:0] tuser, logic tlast);
            sawarq_pkg::res_t want;
            if (pending_results.size() == 0) begin
                $error("result item with nothing expected: action %0d tdata %h",
                       tuser, tdata);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (tuser !== want.action) begin
                $error("action: expected %0d, got %0d", want.action, tuser);
                errors++;
            end
            if (tdata[7:0] !== want.seq) begin
                $error("seq_out: expected %0d, got %0d", want.seq, tdata[7:0]);
                errors++;
            end
            if (tdata[15:8] !== want.dest) begin
                $error("dest_out: expected %0d, got %0d", want.dest, tdata[15:8]);
                errors++;
            end
            if (tdata[17:16] !== want.tcmd) begin
                $error("timer_cmd: expected %0d, got %0d", want.tcmd, tdata[17:16]);
                errors++;
            end
            if (tdata[19:18] !== want.state) begin
                $error("state_out: expected %0d, got %0d", want.state, tdata[19:18]);
                errors++;
            end
            if (tlast !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, tlast);
                errors++;
            end
            if (tdata[23:20] !== 4'h0) begin
                $error("tdata padding: expected 0, got %0d", tdata[23:20]);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------------
    logic                              aclk = 1'b0;
    logic                              aresetn;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [sawarq_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [sawarq_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                              s_axis_tvalid;
    logic                              s_axis_tready;
    logic [15:0]                       s_axis_tdata;   // rx_seq[7:0], rx_source[15:8]
    logic [2:0]                        s_axis_tuser;   // op[2:0]
    logic                              m_axis_tvalid;
    logic                              m_axis_tready;
    logic [23:0]                       m_axis_tdata;   // seq_out[7:0], dest_out[15:8],
                                                       // timer_cmd[17:16],
                                                       // state_out[19:18], zero[23:20]
    logic [2:0]                        m_axis_tuser;   // action[2:0]
    logic                              m_axis_tlast;

    arq_tracker sb;

    // idling controls shared between the sender and the receiver
    bit tx_quiet;       // sender offers back to back
    bit rx_quiet;       // receiver always ready
    bit rx_long_hold;   // one long receiver stall requested

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    stop_and_wait_arq_sender_unit #(
        .SEQ_MODULUS (SEQ_MOD)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    // offer one event item after a gap, note it in the model once accepted
    task automatic drive_event(sawarq_pkg::op_t op, logic [7:0] rx_seq,
                               logic [7:0] rx_source);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 7);
        repeat (gap) begin
            @(negedge aclk);
            s_axis_tvalid = 1'b0;
        end
        @(negedge aclk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = {rx_source, rx_seq};
        do @(posedge aclk); while (!s_axis_tready);
        sb.apply_event(op, rx_seq, rx_source);
    endtask

    // register write, only once the block has delivered everything it owes
    task automatic write_reg(logic [sawarq_pkg::CFG_IDX_W-1:0] idx,
                             logic [sawarq_pkg::CFG_DATA_W-1:0] val);
        @(negedge aclk);
        s_axis_tvalid = 1'b0;
        while (sb.pending_results.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, val);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // pick an event that mostly follows the protocol from the current state,
    // with some noise mixed in
    task automatic send_random_event();
        sawarq_pkg::op_t op;
        logic [7:0]      seq;
        logic [7:0]      src;
        logic [5:0]      hi;
        int              roll;
        roll = $urandom_range(0, 99);
        seq  = 8'($urandom_range(0, 255));
        src  = 8'($urandom_range(0, 255));
        hi   = 6'($urandom_range(1, 63));
        case (sb.proto_state)
            sawarq_pkg::ST_IDLE: begin
                if (roll < 80) op = sawarq_pkg::OP_SEND_REQ;
                else           op = sawarq_pkg::op_t'($urandom_range(0, 7));
            end
            sawarq_pkg::ST_TX: begin
                if (roll < 45)      op = sawarq_pkg::OP_DATA_SENT;
                else if (roll < 65) op = sawarq_pkg::OP_ACK_SENT;
                else if (roll < 82) op = sawarq_pkg::OP_TIMEOUT;
                else                op = sawarq_pkg::op_t'($urandom_range(0, 7));
            end
            default: begin
                if (roll < 38)      op = sawarq_pkg::OP_ACK_RX;
                else if (roll < 62) op = sawarq_pkg::OP_TIMEOUT;
                else if (roll < 78) op = sawarq_pkg::OP_DATA_RX;
                else                op = sawarq_pkg::op_t'($urandom_range(0, 7));
            end
        endcase
        // acks mostly match; some differ only above the low sequence bits
        if (op == sawarq_pkg::OP_ACK_RX) begin
            roll = $urandom_range(0, 9);
            if (roll < 7)      seq = sb.sent_seq;
            else if (roll < 9) seq = {hi, sb.sent_seq[1:0]};
        end
        drive_event(op, seq, src);
    endtask

    // ------------------------------------------------------------------------
    // result side: random stalls, plus one long hold when asked for
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int hold;
        m_axis_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            hold = rx_quiet ? 0 : $urandom_range(0, 7);
            if (rx_long_hold) begin
                hold         = LONG_HOLD;
                rx_long_hold = 1'b0;
            end
            repeat (hold) begin
                @(negedge aclk);
                m_axis_tready = 1'b0;
            end
            @(negedge aclk);
            m_axis_tready = 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
        end
    end

    // every accepted result item is checked against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [7:0] dest_plan[N_PHASES];
        logic [7:0] retry_plan[N_PHASES];

        sb            = new();
        aresetn       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        tx_quiet      = 1'b0;
        rx_quiet      = 1'b0;
        rx_long_hold  = 1'b0;

        dest_plan  = '{8'h00, 8'hFF, 8'($urandom_range(0, 255)), 8'h5A,
                       8'($urandom_range(0, 255)), 8'hFF};
        retry_plan = '{8'd0, 8'd15, 8'd1, 8'd3, 8'($urandom_range(0, 15)), 8'd0};

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed walk: one retry allowed so that give up is quick to reach
        write_reg(sawarq_pkg::CFG_DEST_NODE, 8'hA5);
        write_reg(sawarq_pkg::CFG_MAX_RETRIES, 8'd1);

        drive_event(sawarq_pkg::OP_DATA_SENT, 8'h00, 8'h00);  // ignored in idle, zero fields
        drive_event(sawarq_pkg::OP_RSVD7,     8'hFF, 8'hFF);  // undefined op, all-ones fields
        drive_event(sawarq_pkg::OP_SEND_REQ,  8'h00, 8'h00);  // frame 0 goes out
        drive_event(sawarq_pkg::OP_ACK_RX,    8'h00, 8'h00);  // ack while transmitting: ignored
        drive_event(sawarq_pkg::OP_DATA_RX,   8'h12, 8'h34);  // data while transmitting: ignored
        drive_event(sawarq_pkg::OP_SEND_REQ,  8'h00, 8'h00);  // send request outside idle
        drive_event(sawarq_pkg::OP_DATA_SENT, 8'h00, 8'h00);  // timer starts, wait for ack
        drive_event(sawarq_pkg::OP_DATA_SENT, 8'h00, 8'h00);  // data sent while awaiting ack
        drive_event(sawarq_pkg::OP_ACK_SENT,  8'h00, 8'h00);  // ack sent while awaiting ack
        drive_event(sawarq_pkg::OP_ACK_RX,    8'hFF, 8'h00);  // wrong sequence number
        drive_event(sawarq_pkg::OP_DATA_RX,   8'hFF, 8'hFF);  // peer data: acknowledge it
        drive_event(sawarq_pkg::OP_ACK_SENT,  8'h00, 8'h00);  // timer still runs: back to ack wait
        drive_event(sawarq_pkg::OP_TIMEOUT,   8'h00, 8'h00);  // first resend
        drive_event(sawarq_pkg::OP_TIMEOUT,   8'h00, 8'h00);  // timeout while transmitting
        // deferred timeout: retries used, give up
        drive_event(sawarq_pkg::OP_DATA_SENT, 8'h00, 8'h00);
        drive_event(sawarq_pkg::OP_RSVD6,     8'h00, 8'h00);  // undefined op in idle
        drive_event(sawarq_pkg::OP_SEND_REQ,  8'h00, 8'h00);  // frame 1, retry count cleared
        drive_event(sawarq_pkg::OP_DATA_SENT, 8'h00, 8'h00);
        drive_event(sawarq_pkg::OP_TIMEOUT,   8'h00, 8'h00);  // resend, timer stopped
        drive_event(sawarq_pkg::OP_ACK_SENT,  8'h00, 8'h00);  // no timer, nothing pending: idle
        drive_event(sawarq_pkg::OP_SEND_REQ,  8'h00, 8'h00);  // frame 2
        drive_event(sawarq_pkg::OP_TIMEOUT,   8'h00, 8'h00);  // pending timeout
        drive_event(sawarq_pkg::OP_ACK_SENT,  8'h00, 8'h00);  // deferred timeout gives a resend
        drive_event(sawarq_pkg::OP_DATA_SENT, 8'h00, 8'h00);
        drive_event(sawarq_pkg::OP_ACK_RX,    8'h02, 8'h00);  // matching ack closes frame 2

        // random phases, each with its own register setting and idling mix
        for (int ph = 0; ph < N_PHASES; ph++) begin
            write_reg(sawarq_pkg::CFG_DEST_NODE, dest_plan[ph]);
            write_reg(sawarq_pkg::CFG_MAX_RETRIES, retry_plan[ph]);
            tx_quiet = (ph % 3 == 1);
            rx_quiet = (ph % 3 == 2);
            // back-pressure phase: sender streams while the receiver holds off
            if (ph == 3) begin
                tx_quiet     = 1'b1;
                rx_long_hold = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_random_event();
            end
        end

        @(negedge aclk);
        s_axis_tvalid = 1'b0;
        while (sb.pending_results.size() != 0) @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);

        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("tb_stop_and_wait_arq_sender_unit: PASS");
        end else begin
            $display("tb_stop_and_wait_arq_sender_unit: FAIL");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin : watchdog
        #2_000_000;
        $display("tb_stop_and_wait_arq_sender_unit: FAIL");
        $finish;
    end

endmodule
